### hw/rtl/ljss_pkg.sv
// Shared types, codes and helper functions of the launch jack servo sequencer.
package ljss_pkg;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_ANGLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_ANGLE   = 2'd3;

    localparam logic [15:0] OPEN_DELAY_RST   = 16'd5000;
    localparam logic [15:0] BLINK_PERIOD_RST = 16'd300;
    localparam logic [7:0]  OPEN_ANGLE_RST   = 8'd90;
    localparam logic [7:0]  REST_ANGLE_RST   = 8'd0;

    localparam logic [7:0]  MAX_ANGLE = 8'd180;

    // Reported system state codes.
    localparam logic [2:0] SYS_OFF        = 3'd0;
    localparam logic [2:0] SYS_WAITING    = 3'd1;
    localparam logic [2:0] SYS_CALCULO    = 3'd2;
    localparam logic [2:0] SYS_EXPERIENCE = 3'd3;
    localparam logic [2:0] SYS_TIMING     = 3'd4;
    localparam logic [2:0] SYS_OPEN       = 3'd5;
    localparam logic [2:0] SYS_CLOSED     = 3'd6;

    // Mode codes.
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_CALC  = 2'd1;
    localparam logic [1:0] MODE_EXPER = 2'd2;

    // Maintenance command characters.
    localparam logic [7:0] CMD_OPEN_LC   = 8'h6F;
    localparam logic [7:0] CMD_OPEN_UC   = 8'h4F;
    localparam logic [7:0] CMD_CLOSE_LC  = 8'h63;
    localparam logic [7:0] CMD_CLOSE_UC  = 8'h43;
    localparam logic [7:0] CMD_TOGGLE_LC = 8'h74;
    localparam logic [7:0] CMD_TOGGLE_UC = 8'h54;

    typedef enum logic [5:0] {
        SEQ_WAITING    = 6'b000001,
        SEQ_CALCULO    = 6'b000010,
        SEQ_EXPERIENCE = 6'b000100,
        SEQ_TIMING     = 6'b001000,
        SEQ_OPEN       = 6'b010000,
        SEQ_CLOSED     = 6'b100000
    } seq_state_t;

    function automatic logic [2:0] seq_code(input seq_state_t s);
        logic [2:0] code;
        unique case (s)
            SEQ_WAITING:    code = SYS_WAITING;
            SEQ_CALCULO:    code = SYS_CALCULO;
            SEQ_EXPERIENCE: code = SYS_EXPERIENCE;
            SEQ_TIMING:     code = SYS_TIMING;
            SEQ_OPEN:       code = SYS_OPEN;
            SEQ_CLOSED:     code = SYS_CLOSED;
            default:        code = SYS_OFF;
        endcase
        return code;
    endfunction

    // Clamp a commanded angle to the servo's mechanical range.
    function automatic logic [7:0] sat_angle(input logic [7:0] a);
        return (a > MAX_ANGLE) ? MAX_ANGLE : a;
    endfunction

endpackage

### hw/rtl/ljss_in_if.sv
// Tick channel interface: valid/ready handshake with the per-tick inputs.
interface ljss_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        jack_present;
    logic        calculo_on;
    logic        experience_on;
    logic        button_rose;
    logic        command_valid;
    logic [7:0]  command_code;

    modport source (
        output valid, now_ms, jack_present, calculo_on, experience_on,
               button_rose, command_valid, command_code,
        input  ready
    );
    modport sink (
        input  valid, now_ms, jack_present, calculo_on, experience_on,
               button_rose, command_valid, command_code,
        output ready
    );
    modport monitor (
        input  valid, ready, now_ms, jack_present, calculo_on, experience_on,
               button_rose, command_valid, command_code
    );
endinterface

### hw/rtl/ljss_out_if.sv
// Result channel interface: valid/ready handshake with the per-tick outputs.
interface ljss_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] system_state;
    logic [1:0] active_mode;
    logic       servo_is_open;
    logic [7:0] servo_angle;
    logic       timer_active;
    logic       led_experience;
    logic       led_jack;

    modport source (
        output valid, system_state, active_mode, servo_is_open, servo_angle,
               timer_active, led_experience, led_jack,
        input  ready
    );
    modport sink (
        input  valid, system_state, active_mode, servo_is_open, servo_angle,
               timer_active, led_experience, led_jack,
        output ready
    );
    modport monitor (
        input  valid, ready, system_state, active_mode, servo_is_open,
               servo_angle, timer_active, led_experience, led_jack
    );
endinterface

### hw/rtl/launch_jack_servo_sequencer.sv
// Launch jack servo sequencer: per-tick mode, timer, servo and LED control.
//
// Usage: the control loop sends one item per tick on the tick channel (time in
// ms, debounced jack/calculo/experience levels, button edge, optional command
// character). For every accepted item exactly one result item leaves on the
// result channel, in order, carrying the system state, mode, servo position,
// timer flag and both LED levels.
// An accepted item sits in the input register; when the result register is empty
// or being emptied, its result is loaded there and offered on the result channel.
// Throughput is one item per cycle while results are taken; the tick logic is a
// handful of flag updates and two 32-bit wrap-around subtract-and-compare paths,
// all settling between the input register and the result register.
// When the receiver stalls, the finished result holds in the result register
// and the input register still takes one more item; after that ready drops
// until the result is taken.
// Reset clears both channel stages, puts the sequence in the waiting state with
// the servo closed at angle 0, and loads the configuration defaults (open delay
// 5000 ms, blink period 300 ms, open angle 90, rest angle 0). Configuration is
// written through cfg_we/cfg_index/cfg_data while no item is in flight.
module launch_jack_servo_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ljss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ljss_pkg::CFG_DATA_W-1:0] cfg_data,
    ljss_in_if.sink                        tick,
    ljss_out_if.source                     result
);
    import ljss_pkg::*;

    // Configuration registers.
    logic [15:0] open_delay_reg;
    logic [15:0] blink_period_reg;
    logic [7:0]  open_angle_reg;
    logic [7:0]  rest_angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_delay_reg   <= OPEN_DELAY_RST;
            blink_period_reg <= BLINK_PERIOD_RST;
            open_angle_reg   <= OPEN_ANGLE_RST;
            rest_angle_reg   <= REST_ANGLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OPEN_DELAY:   open_delay_reg   <= cfg_data[15:0];
                CFG_BLINK_PERIOD: blink_period_reg <= cfg_data[15:0];
                CFG_OPEN_ANGLE:   open_angle_reg   <= cfg_data[7:0];
                CFG_REST_ANGLE:   rest_angle_reg   <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Input register stage. The tick logic fires when an item sits here and
    // the result register is empty or being emptied in this cycle.
    logic        in_vld_reg;
    logic [31:0] now_reg;
    logic        jack_reg;
    logic        calc_reg;
    logic        expe_reg;
    logic        rose_reg;
    logic        cvalid_reg;
    logic [7:0]  code_reg;
    logic        fire;
    logic        out_vld_reg;

    assign fire       = in_vld_reg && (!out_vld_reg || result.ready);
    assign tick.ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_vld_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            now_reg    <= tick.now_ms;
            jack_reg   <= tick.jack_present;
            calc_reg   <= tick.calculo_on;
            expe_reg   <= tick.experience_on;
            rose_reg   <= tick.button_rose;
            cvalid_reg <= tick.command_valid;
            code_reg   <= tick.command_code;
        end
    end

    // Sequencer state.
    seq_state_t  seq_reg, seq_next;
    logic [1:0]  mode_reg, mode_next;
    logic        sopen_reg, sopen_next;
    logic [7:0]  angle_reg, angle_next;
    logic        trun_reg, trun_next;
    logic [31:0] tstart_reg, tstart_next;
    logic        eblink_reg, eblink_next;
    logic        jblink_reg, jblink_next;
    logic [31:0] lblink_reg, lblink_next;
    logic        phase_reg, phase_next;
    logic        led_exp_next;
    logic        led_jack_next;

    // Decoded maintenance command.
    logic cmd_open;
    logic cmd_close;
    logic cmd_toggle;
    logic flag_after_expiry;
    logic force_en;
    logic force_open;
    logic [31:0] elapsed;
    logic [31:0] blink_elapsed;

    assign cmd_open   = cvalid_reg && (code_reg == CMD_OPEN_LC   || code_reg == CMD_OPEN_UC);
    assign cmd_close  = cvalid_reg && (code_reg == CMD_CLOSE_LC  || code_reg == CMD_CLOSE_UC);
    assign cmd_toggle = cvalid_reg && (code_reg == CMD_TOGGLE_LC || code_reg == CMD_TOGGLE_UC);

    always_comb
    begin
        seq_next      = seq_reg;
        mode_next     = mode_reg;
        sopen_next    = sopen_reg;
        angle_next    = angle_reg;
        trun_next     = trun_reg;
        tstart_next   = tstart_reg;
        eblink_next   = eblink_reg;
        jblink_next   = jblink_reg;
        lblink_next   = lblink_reg;
        phase_next    = phase_reg;
        led_exp_next  = 1'b0;
        led_jack_next = 1'b0;
        flag_after_expiry = sopen_reg;
        force_en      = 1'b0;
        force_open    = 1'b0;
        elapsed       = '0;
        blink_elapsed = '0;

        if (!jack_reg)
        begin
            // Jack pulled: abort everything and close the servo if it was open.
            trun_next   = 1'b0;
            jblink_next = 1'b0;
            eblink_next = 1'b0;
            if (sopen_reg)
            begin
                sopen_next = 1'b0;
                angle_next = sat_angle(rest_angle_reg);
            end
            seq_next  = SEQ_WAITING;
            mode_next = MODE_NONE;
        end
        else
        begin
            // Mode resolution; both switches on is an error.
            if (calc_reg && expe_reg)
            begin
                jblink_next = 1'b1;
                trun_next   = 1'b0;
                eblink_next = 1'b0;
                mode_next   = MODE_NONE;
                seq_next    = SEQ_WAITING;
            end
            else
            begin
                jblink_next = 1'b0;
                priority if (calc_reg)
                begin
                    mode_next = MODE_CALC;
                    if (!trun_reg) seq_next = SEQ_CALCULO;
                end
                else if (expe_reg)
                begin
                    mode_next = MODE_EXPER;
                    if (!trun_reg) seq_next = SEQ_EXPERIENCE;
                end
                else
                begin
                    mode_next = MODE_NONE;
                    if (!trun_reg) seq_next = SEQ_WAITING;
                end
            end

            // A selected mode arms the one-shot timer once.
            if (mode_next != MODE_NONE && !trun_next && !sopen_reg)
            begin
                trun_next   = 1'b1;
                tstart_next = now_reg;
                seq_next    = SEQ_TIMING;
                eblink_next = 1'b1;
            end

            // Expiry check uses the possibly just-loaded start time, so a zero
            // delay opens the servo in the same tick.
            elapsed = now_reg - tstart_next;
            if (trun_next && (elapsed >= {16'd0, open_delay_reg}))
            begin
                trun_next   = 1'b0;
                eblink_next = 1'b0;
                sopen_next  = 1'b1;
                angle_next  = sat_angle(open_angle_reg);
                seq_next    = SEQ_OPEN;
            end
            flag_after_expiry = sopen_next;

            // The button acts first, then the command; only the last one counts,
            // but a toggle command sees the flag the button left behind.
            if (rose_reg)
            begin
                force_en   = 1'b1;
                force_open = !flag_after_expiry;
            end
            priority if (cmd_open)
            begin
                force_en   = 1'b1;
                force_open = 1'b1;
            end
            else if (cmd_close)
            begin
                force_en   = 1'b1;
                force_open = 1'b0;
            end
            else if (cmd_toggle)
            begin
                force_en   = 1'b1;
                force_open = rose_reg ? flag_after_expiry : !flag_after_expiry;
            end
            else
            begin
                force_en = force_en;
            end

            if (force_en)
            begin
                sopen_next  = force_open;
                trun_next   = 1'b0;
                eblink_next = 1'b0;
                angle_next  = sat_angle(force_open ? open_angle_reg : rest_angle_reg);
                seq_next    = force_open ? SEQ_OPEN : SEQ_CLOSED;
            end

            // Shared blink phase.
            blink_elapsed = now_reg - lblink_reg;
            if (blink_elapsed >= {16'd0, blink_period_reg})
            begin
                lblink_next = now_reg;
                phase_next  = !phase_reg;
            end

            led_jack_next = jblink_next ? phase_next : 1'b1;
            led_exp_next  = eblink_next ? phase_next : (mode_next == MODE_EXPER);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= SEQ_WAITING;
            mode_reg   <= MODE_NONE;
            sopen_reg  <= 1'b0;
            angle_reg  <= REST_ANGLE_RST;
            trun_reg   <= 1'b0;
            tstart_reg <= '0;
            eblink_reg <= 1'b0;
            jblink_reg <= 1'b0;
            lblink_reg <= '0;
            phase_reg  <= 1'b0;
        end
        else if (fire)
        begin
            seq_reg    <= seq_next;
            mode_reg   <= mode_next;
            sopen_reg  <= sopen_next;
            angle_reg  <= angle_next;
            trun_reg   <= trun_next;
            tstart_reg <= tstart_next;
            eblink_reg <= eblink_next;
            jblink_reg <= jblink_next;
            lblink_reg <= lblink_next;
            phase_reg  <= phase_next;
        end
    end

    // Result register.
    logic [2:0] res_state_reg;
    logic [1:0] res_mode_reg;
    logic       res_open_reg;
    logic [7:0] res_angle_reg;
    logic       res_timer_reg;
    logic       res_led_exp_reg;
    logic       res_led_jack_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_state_reg    <= seq_code(seq_next);
            res_mode_reg     <= mode_next;
            res_open_reg     <= sopen_next;
            res_angle_reg    <= angle_next;
            res_timer_reg    <= trun_next;
            res_led_exp_reg  <= led_exp_next;
            res_led_jack_reg <= led_jack_next;
        end
    end

    assign result.valid          = out_vld_reg;
    assign result.system_state   = res_state_reg;
    assign result.active_mode    = res_mode_reg;
    assign result.servo_is_open  = res_open_reg;
    assign result.servo_angle    = res_angle_reg;
    assign result.timer_active   = res_timer_reg;
    assign result.led_experience = res_led_exp_reg;
    assign result.led_jack       = res_led_jack_reg;

endmodule

### hw/rtl/ljss_checker.sv
// Port-level checker for the launch jack servo sequencer and its bind.
module ljss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic [2:0] system_state,
    input logic [1:0] active_mode,
    input logic [7:0] servo_angle,
    input logic       timer_active,
    input logic       led_jack
);
    import ljss_pkg::*;

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item withdrawn while stalled");

    // The commanded angle is always clamped to the servo range.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> servo_angle <= MAX_ANGLE)
        else $error("servo angle above limit");

    // The timer runs exactly when the sequence reports the timing state.
    a_timer_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (timer_active == (system_state == SYS_TIMING)))
        else $error("timer flag and timing state disagree");

    // A resolved mode means the jack is in and there is no mode error.
    a_mode_led: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && active_mode != MODE_NONE |-> led_jack)
        else $error("jack LED not steady with a valid mode");

endmodule

bind launch_jack_servo_sequencer ljss_checker u_ljss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .system_state (result.system_state),
    .active_mode  (result.active_mode),
    .servo_angle  (result.servo_angle),
    .timer_active (result.timer_active),
    .led_jack     (result.led_jack)
);

### dv/testbench.sv
// Self-checking testbench for the launch jack servo sequencer: stimulus, prediction and checks.
module testbench;

    import ljss_pkg::*;

    // One tick offered to the block and one result taken from it, in the
    // widths of the channel interfaces.
    typedef struct {
        logic [31:0] now_ms;
        logic        jack_present;
        logic        calculo_on;
        logic        experience_on;
        logic        button_rose;
        logic        command_valid;
        logic [7:0]  command_code;
    } tick_t;

    typedef struct {
        logic [2:0] system_state;
        logic [1:0] active_mode;
        logic       servo_is_open;
        logic [7:0] servo_angle;
        logic       timer_active;
        logic       led_experience;
        logic       led_jack;
    } result_t;

    // The scoreboard keeps its own copy of the sequencer state and of the
    // four configuration registers. Every accepted tick is run through the
    // same decisions the block makes, and the outcome waits in a queue until
    // the block delivers its result item.
    class servo_scoreboard;
        logic [15:0] open_delay;
        logic [15:0] blink_period;
        logic [7:0]  open_ang;
        logic [7:0]  rest_ang;

        logic [2:0]  state;
        logic [1:0]  mode;
        logic        servo_open;
        logic [7:0]  angle;
        logic        timing;
        logic [31:0] timer_t0;
        logic        exp_blink;
        logic        jack_blink;
        logic [31:0] last_toggle;
        logic        blink_phase;

        result_t     awaited[$];
        int          failures;

        function new();
            open_delay   = OPEN_DELAY_RST;
            blink_period = BLINK_PERIOD_RST;
            open_ang     = OPEN_ANGLE_RST;
            rest_ang     = REST_ANGLE_RST;
            state        = SYS_WAITING;
            mode         = MODE_NONE;
            servo_open   = 1'b0;
            angle        = 8'd0;
            timing       = 1'b0;
            timer_t0     = 32'd0;
            exp_blink    = 1'b0;
            jack_blink   = 1'b0;
            last_toggle  = 32'd0;
            blink_phase  = 1'b0;
            failures     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OPEN_DELAY:   open_delay   = data;
                CFG_BLINK_PERIOD: blink_period = data;
                CFG_OPEN_ANGLE:   open_ang     = data[7:0];
                CFG_REST_ANGLE:   rest_ang     = data[7:0];
                default: ;
            endcase
        endfunction

        // The angle sent to the servo never goes past its mechanical stop.
        function logic [7:0] servo_target(logic open);
            logic [7:0] a;
            a = open ? open_ang : rest_ang;
            return (a > MAX_ANGLE) ? MAX_ANGLE : a;
        endfunction

        // Button and maintenance commands override the automatic sequence.
        function void force_servo(logic open);
            servo_open = open;
            timing     = 1'b0;
            exp_blink  = 1'b0;
            angle      = servo_target(open);
            state      = open ? SYS_OPEN : SYS_CLOSED;
        endfunction

        function void note_tick(tick_t t);
            logic [2:0]  sel_state;
            logic [31:0] elapsed;
            logic        led_e;
            logic        led_j;
            result_t     r;
            if (!t.jack_present) begin
                // Without the jack everything is cancelled and the LEDs go dark;
                // the blink phase stands still.
                timing     = 1'b0;
                jack_blink = 1'b0;
                exp_blink  = 1'b0;
                if (servo_open) begin
                    servo_open = 1'b0;
                    angle      = servo_target(1'b0);
                end
                state = SYS_WAITING;
                mode  = MODE_NONE;
                led_e = 1'b0;
                led_j = 1'b0;
            end else begin
                if (t.calculo_on && t.experience_on) begin
                    // Both switches on is a setup error.
                    jack_blink = 1'b1;
                    timing     = 1'b0;
                    exp_blink  = 1'b0;
                    mode       = MODE_NONE;
                    state      = SYS_WAITING;
                end else begin
                    jack_blink = 1'b0;
                    if (t.calculo_on) begin
                        mode      = MODE_CALC;
                        sel_state = SYS_CALCULO;
                    end else if (t.experience_on) begin
                        mode      = MODE_EXPER;
                        sel_state = SYS_EXPERIENCE;
                    end else begin
                        mode      = MODE_NONE;
                        sel_state = SYS_WAITING;
                    end
                    if (!timing)
                        state = sel_state;
                end

                if (mode != MODE_NONE && !timing && !servo_open) begin
                    timing    = 1'b1;
                    timer_t0  = t.now_ms;
                    state     = SYS_TIMING;
                    exp_blink = 1'b1;
                end

                elapsed = t.now_ms - timer_t0;
                if (timing && elapsed >= {16'd0, open_delay}) begin
                    timing     = 1'b0;
                    exp_blink  = 1'b0;
                    servo_open = 1'b1;
                    angle      = servo_target(1'b1);
                    state      = SYS_OPEN;
                end

                if (t.button_rose)
                    force_servo(!servo_open);

                if (t.command_valid) begin
                    case (t.command_code)
                        CMD_OPEN_LC, CMD_OPEN_UC:     force_servo(1'b1);
                        CMD_CLOSE_LC, CMD_CLOSE_UC:   force_servo(1'b0);
                        CMD_TOGGLE_LC, CMD_TOGGLE_UC: force_servo(!servo_open);
                        default: ;
                    endcase
                end

                elapsed = t.now_ms - last_toggle;
                if (elapsed >= {16'd0, blink_period}) begin
                    last_toggle = t.now_ms;
                    blink_phase = !blink_phase;
                end

                led_j = jack_blink ? blink_phase : 1'b1;
                led_e = exp_blink ? blink_phase : (mode == MODE_EXPER);
            end

            r.system_state   = state;
            r.active_mode    = mode;
            r.servo_is_open  = servo_open;
            r.servo_angle    = angle;
            r.timer_active   = timing;
            r.led_experience = led_e;
            r.led_jack       = led_j;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                $error("result item arrived with no tick waiting for it");
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("system_state", 8'(want.system_state), 8'(got.system_state));
            compare_field("active_mode", 8'(want.active_mode), 8'(got.active_mode));
            compare_field("servo_is_open", 8'(want.servo_is_open), 8'(got.servo_is_open));
            compare_field("servo_angle", want.servo_angle, got.servo_angle);
            compare_field("timer_active", 8'(want.timer_active), 8'(got.timer_active));
            compare_field("led_experience", 8'(want.led_experience),
                          8'(got.led_experience));
            compare_field("led_jack", 8'(want.led_jack), 8'(got.led_jack));
        endfunction

        function bit all_clear();
            if (awaited.size() != 0) begin
                $error("%0d result items never arrived", awaited.size());
                failures++;
            end
            return failures == 0;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ljss_in_if  tick_ch ();
    ljss_out_if result_ch ();

    launch_jack_servo_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (result_ch)
    );

    servo_scoreboard sb = new();

    // While steady is set neither side inserts gaps, which gives one long
    // stretch of back-to-back items.
    bit steady = 1'b0;

    // State of the random tick generator: the millisecond clock and the two
    // mode switches, which are kept sticky so the timer gets time to expire.
    logic [31:0] clock_ms = 32'd0;
    logic        sw_calc  = 1'b0;
    logic        sw_exp   = 1'b0;

    logic [7:0] command_set[6] = '{CMD_OPEN_LC, CMD_OPEN_UC, CMD_CLOSE_LC,
                                   CMD_CLOSE_UC, CMD_TOGGLE_LC, CMD_TOGGLE_UC};

    always #10 clk = ~clk;

    // The whole run must fit well inside this; a hang ends here.
    initial begin
        #4000000;
        $display("testbench: FAIL");
        $finish;
    end

    // Offers one tick and returns at the falling edge after it was accepted.
    // Called at a falling edge. Valid stays high on return, so the next call
    // either re-drives it or lowers it, one assignment per edge.
    task automatic send_tick(input tick_t t);
        while (!steady && $urandom_range(99) < 7) begin
            // Gap: valid low with garbage on the payload, which must be ignored.
            tick_ch.valid         = 1'b0;
            tick_ch.now_ms        = $urandom();
            tick_ch.jack_present  = 1'($urandom_range(1));
            tick_ch.button_rose   = 1'($urandom_range(1));
            tick_ch.command_valid = 1'($urandom_range(1));
            tick_ch.command_code  = 8'($urandom_range(255));
            @(negedge clk);
        end
        tick_ch.valid         = 1'b1;
        tick_ch.now_ms        = t.now_ms;
        tick_ch.jack_present  = t.jack_present;
        tick_ch.calculo_on    = t.calculo_on;
        tick_ch.experience_on = t.experience_on;
        tick_ch.button_rose   = t.button_rose;
        tick_ch.command_valid = t.command_valid;
        tick_ch.command_code  = t.command_code;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        sb.note_tick(t);
        @(negedge clk);
    endtask

    function automatic tick_t make_tick(logic [31:0] now, logic jack, logic calc,
                                        logic expe, logic rose, logic cv,
                                        logic [7:0] code);
        tick_t t;
        t.now_ms        = now;
        t.jack_present  = jack;
        t.calculo_on    = calc;
        t.experience_on = expe;
        t.button_rose   = rose;
        t.command_valid = cv;
        t.command_code  = code;
        return t;
    endfunction

    // Stop offering ticks and wait until the block has handed back every
    // result; afterwards nothing is in flight, since each tick gives a result.
    task automatic drain();
        tick_ch.valid = 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
    endtask

    // One register write per clock edge, driven at the falling edge.
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input logic [15:0] delay, input logic [15:0] period,
                             input logic [7:0] open_a, input logic [7:0] rest_a);
        program_reg(CFG_OPEN_DELAY, delay);
        program_reg(CFG_BLINK_PERIOD, period);
        program_reg(CFG_OPEN_ANGLE, {8'd0, open_a});
        program_reg(CFG_REST_ANGLE, {8'd0, rest_a});
        cfg_we = 1'b0;
    endtask

    // Mostly in-range angles, now and then one past the servo's stop.
    function automatic logic [7:0] random_angle();
        if ($urandom_range(99) < 10)
            return 8'($urandom_range(255, 181));
        return 8'($urandom_range(180));
    endfunction

    // Directed ticks under the reset configuration (delay 5000 ms, blink
    // period 300 ms, open angle 90, rest angle 0).
    task automatic run_directed();
        // Jack absent: every other request in the tick is ignored.
        send_tick(make_tick(32'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, CMD_OPEN_LC));
        send_tick(make_tick(32'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        // Both modes on is an error and blinks the jack LED.
        send_tick(make_tick(32'd20, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(32'd400, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'hFF));
        // Calculo mode: the timer starts, runs and opens the servo.
        send_tick(make_tick(32'd1000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(32'd3000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(32'd6000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        // Button toggles, then every maintenance command in both cases.
        send_tick(make_tick(32'd6010, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
        send_tick(make_tick(32'd6020, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, CMD_OPEN_UC));
        send_tick(make_tick(32'd6030, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, CMD_CLOSE_LC));
        send_tick(make_tick(32'd6035, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, CMD_OPEN_LC));
        send_tick(make_tick(32'd6040, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, CMD_CLOSE_UC));
        send_tick(make_tick(32'd6050, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, CMD_TOGGLE_LC));
        send_tick(make_tick(32'd6060, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, CMD_TOGGLE_UC));
        // A known code without command_valid does nothing.
        send_tick(make_tick(32'd6070, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, CMD_OPEN_LC));
        // Button and command together: the button acts first.
        send_tick(make_tick(32'd6080, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, CMD_CLOSE_LC));
        // Experience mode starts the timer; a command then forces the servo.
        send_tick(make_tick(32'd6090, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(32'd6100, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, CMD_OPEN_LC));
        // Pulling the jack with the servo open closes it.
        send_tick(make_tick(32'd6110, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        // Timer started just before the time wraps and expiring after it.
        send_tick(make_tick(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(32'h0000_0010, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(32'h0000_1400, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
        send_tick(make_tick(32'hAAAA_5555, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, CMD_TOGGLE_LC));
        send_tick(make_tick(32'h5555_AAAA, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF));
    endtask

    // Random ticks shaped like a real control loop: time mostly creeps
    // forward in small steps, sometimes in larger ones, and rarely jumps
    // anywhere. The mode switches mostly hold their level so that timers run
    // to expiry; the jack is mostly present.
    task automatic send_random_ticks(input int count);
        tick_t t;
        int    roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 80)
                clock_ms = clock_ms + $urandom_range(40);
            else if (roll < 95)
                clock_ms = clock_ms + $urandom_range(3000);
            else
                clock_ms = $urandom();
            if ($urandom_range(99) < 10)
                sw_calc = !sw_calc;
            if ($urandom_range(99) < 10)
                sw_exp = !sw_exp;
            // Keep the error combination from dominating.
            if (sw_calc && sw_exp && $urandom_range(1) == 0)
                sw_calc = 1'b0;
            t.now_ms        = clock_ms;
            t.jack_present  = ($urandom_range(99) < 90);
            t.calculo_on    = sw_calc;
            t.experience_on = sw_exp;
            t.button_rose   = ($urandom_range(99) < 5);
            t.command_valid = ($urandom_range(99) < 10);
            if ($urandom_range(99) < 60)
                t.command_code = command_set[3'($urandom_range(5))];
            else
                t.command_code = 8'($urandom_range(255));
            send_tick(t);
        end
    endtask

    // Result side: ready is dropped at random, except for one long hold-off
    // counted here, during which the sender keeps offering ticks so that the
    // block fills up and stalls its input.
    initial begin
        int results_seen;
        int hold_left;
        result_t got;
        results_seen    = 0;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                result_ch.ready = 1'b0;
                hold_left--;
            end else begin
                result_ch.ready = steady || ($urandom_range(99) >= 7);
            end
            @(posedge clk);
            if (result_ch.valid && result_ch.ready) begin
                got.system_state   = result_ch.system_state;
                got.active_mode    = result_ch.active_mode;
                got.servo_is_open  = result_ch.servo_is_open;
                got.servo_angle    = result_ch.servo_angle;
                got.timer_active   = result_ch.timer_active;
                got.led_experience = result_ch.led_experience;
                got.led_jack       = result_ch.led_jack;
                sb.check_result(got);
                results_seen++;
                if (results_seen == 600)
                    hold_left = 200;
            end
        end
    end

    // Main sequence: reset, directed ticks under the reset configuration,
    // then random phases, each under its own configuration written while
    // the block is empty.
    initial begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_OPEN_DELAY;
        cfg_data              = '0;
        tick_ch.valid         = 1'b0;
        tick_ch.now_ms        = 32'd0;
        tick_ch.jack_present  = 1'b0;
        tick_ch.calculo_on    = 1'b0;
        tick_ch.experience_on = 1'b0;
        tick_ch.button_rose   = 1'b0;
        tick_ch.command_valid = 1'b0;
        tick_ch.command_code  = 8'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        // Zero delay and zero blink period, with both angles past the stop.
        drain();
        configure(16'd0, 16'd0, 8'd255, 8'd200);
        send_random_ticks(120);

        // Largest delay and period; open and rest angles swapped to the extremes.
        drain();
        configure(16'hFFFF, 16'hFFFF, 8'd0, 8'd180);
        send_random_ticks(120);

        // A long stretch without any gaps on either side.
        drain();
        configure(16'd100, 16'd1, 8'd180, 8'd0);
        steady = 1'b1;
        send_random_ticks(200);
        steady = 1'b0;

        // Random settings with short delays so the timer expires often.
        for (int p = 0; p < 3; p++) begin
            drain();
            configure(16'($urandom_range(400)), 16'($urandom_range(200, 1)),
                      random_angle(), random_angle());
            send_random_ticks(170);
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.all_clear())
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
